// ===== src/hwhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwhc_pkg
// Shared types and codes of the humidity wiper and heater controller.
// ----------------------------------------------------------------------------
package hwhc_pkg;

  localparam int HUM_W  = 10;
  localparam int HYS_W  = 7;
  localparam int LIM_W  = 16;
  localparam int STAMP_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] OP_MODE   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] MODE_AUTO = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;
  localparam logic [1:0] MODE_KEEP = 2'd3;

  localparam logic [1:0] SPD_STOP   = 2'd0;
  localparam logic [1:0] SPD_SLOW   = 2'd1;
  localparam logic [1:0] SPD_NORMAL = 2'd2;
  localparam logic [1:0] SPD_FAST   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIPER_HYS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEATER_THR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEATER_HYS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIM  = 3'd6;

  localparam logic [HUM_W-1:0] RST_SLOW_THR   = 10'd300;
  localparam logic [HUM_W-1:0] RST_NORMAL_THR = 10'd350;
  localparam logic [HUM_W-1:0] RST_FAST_THR   = 10'd400;
  localparam logic [HYS_W-1:0] RST_WIPER_HYS  = 7'd5;
  localparam logic [HUM_W-1:0] RST_HEATER_THR = 10'd350;
  localparam logic [HYS_W-1:0] RST_HEATER_HYS = 7'd5;
  localparam logic [LIM_W-1:0] RST_STALE_LIM  = 16'd5000;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         wiper_mode_req;
    logic [1:0]         heater_mode_req;
    logic [HUM_W-1:0]   humidity_tenths;
    logic [STAMP_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         wiper_speed;
    logic               heater_on;
    logic               speed_changed;
    logic               heater_changed;
    logic [STAMP_W-1:0] stamp_ms;
  } out_item_t;

  typedef struct packed {
    logic [HUM_W-1:0] slow_threshold;
    logic [HUM_W-1:0] normal_threshold;
    logic [HUM_W-1:0] fast_threshold;
    logic [HYS_W-1:0] wiper_hysteresis;
    logic [HUM_W-1:0] heater_threshold;
    logic [HYS_W-1:0] heater_hysteresis;
    logic [LIM_W-1:0] stale_limit_ms;
  } cfg_regs_t;

  // Handshake state between the input register and the decision stage.
  typedef struct packed {
    logic valid;
  } stage_ctl_t;

  // True when h is strictly below thr minus hys, never negative.
  function automatic logic below_margin(input logic [HUM_W-1:0] h,
                                        input logic [HUM_W-1:0] thr,
                                        input logic [HYS_W-1:0] hys);
    logic [HUM_W:0] sum;
    sum = {1'b0, h} + {{(HUM_W-HYS_W+1){1'b0}}, hys};
    return sum < {1'b0, thr};
  endfunction

endpackage

// ===== src/hwhc_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwhc_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface hwhc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/hwhc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwhc_cfg_regs
// Threshold, hysteresis and stale limit registers behind the write port.
// ----------------------------------------------------------------------------
module hwhc_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [hwhc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hwhc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output hwhc_pkg::cfg_regs_t                  regs
);

  hwhc_pkg::cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.slow_threshold    <= hwhc_pkg::RST_SLOW_THR;
      regs_r.normal_threshold  <= hwhc_pkg::RST_NORMAL_THR;
      regs_r.fast_threshold    <= hwhc_pkg::RST_FAST_THR;
      regs_r.wiper_hysteresis  <= hwhc_pkg::RST_WIPER_HYS;
      regs_r.heater_threshold  <= hwhc_pkg::RST_HEATER_THR;
      regs_r.heater_hysteresis <= hwhc_pkg::RST_HEATER_HYS;
      regs_r.stale_limit_ms    <= hwhc_pkg::RST_STALE_LIM;
    end else if (cfg_we) begin
      case (cfg_index)
        hwhc_pkg::CFG_SLOW_THR:   regs_r.slow_threshold    <= cfg_data[hwhc_pkg::HUM_W-1:0];
        hwhc_pkg::CFG_NORMAL_THR: regs_r.normal_threshold  <= cfg_data[hwhc_pkg::HUM_W-1:0];
        hwhc_pkg::CFG_FAST_THR:   regs_r.fast_threshold    <= cfg_data[hwhc_pkg::HUM_W-1:0];
        hwhc_pkg::CFG_WIPER_HYS:  regs_r.wiper_hysteresis  <= cfg_data[hwhc_pkg::HYS_W-1:0];
        hwhc_pkg::CFG_HEATER_THR: regs_r.heater_threshold  <= cfg_data[hwhc_pkg::HUM_W-1:0];
        hwhc_pkg::CFG_HEATER_HYS: regs_r.heater_hysteresis <= cfg_data[hwhc_pkg::HYS_W-1:0];
        hwhc_pkg::CFG_STALE_LIM:  regs_r.stale_limit_ms    <= cfg_data[hwhc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

// ===== src/hwhc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwhc_in_stage
// Input register: capture one item per transfer, hold it until decided.
// ----------------------------------------------------------------------------
module hwhc_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  hwhc_stream_if.sink          in_if,
  input  logic                 advance,
  output hwhc_pkg::stage_ctl_t ctl,
  output hwhc_pkg::in_item_t   item
);

  logic               valid_r;
  logic               valid_nxt;
  hwhc_pkg::in_item_t item_r;
  logic               take;

  assign in_if.ready = !valid_r || advance;
  assign take        = in_if.valid && in_if.ready;
  assign valid_nxt   = take || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_if.data;
    end
  end

  assign ctl.valid   = valid_r;
  assign item        = item_r;

endmodule

// ===== src/hwhc_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwhc_decide
// Mode, auto hysteresis and freshness state; final command and change check.
// ----------------------------------------------------------------------------
module hwhc_decide #(
  parameter int TICK_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hwhc_pkg::cfg_regs_t  cfg,
  input  hwhc_pkg::stage_ctl_t ctl,
  input  hwhc_pkg::in_item_t   item,
  input  logic                 out_free,
  output logic                 advance,
  output logic                 emit,
  output hwhc_pkg::out_item_t  result
);

  logic [1:0]           wiper_mode_r, wiper_mode_nxt;
  logic [1:0]           heater_mode_r, heater_mode_nxt;
  logic [1:0]           auto_speed_r, auto_speed_nxt;
  logic                 auto_speed_valid_r, auto_speed_valid_nxt;
  logic                 auto_heater_r, auto_heater_nxt;
  logic                 auto_heater_valid_r, auto_heater_valid_nxt;
  logic [TICK_BITS-1:0] sample_time_r, sample_time_nxt;
  logic                 have_sample_r, have_sample_nxt;
  logic [1:0]           sent_speed_r, sent_speed_nxt;
  logic                 speed_sent_r, speed_sent_nxt;
  logic                 sent_heater_r, sent_heater_nxt;
  logic                 heater_sent_r, heater_sent_nxt;

  logic [TICK_BITS+31:0] now_wide;
  logic [TICK_BITS+15:0] lim_wide;
  logic [TICK_BITS-1:0]  now_tk;
  logic [TICK_BITS-1:0]  lim_tk;
  logic [TICK_BITS-1:0]  age;
  logic                  stale;
  logic [1:0]            spd_up;
  logic [1:0]            spd_a;
  logic [1:0]            spd_b;
  logic [1:0]            spd_c;
  logic [1:0]            spd_class;
  logic [1:0]            speed;
  logic                  heat;
  logic                  sc;
  logic                  hc;
  logic [hwhc_pkg::HUM_W-1:0] h;

  assign h        = item.humidity_tenths;
  assign now_wide = {{TICK_BITS{1'b0}}, item.now_ms};
  assign now_tk   = now_wide[TICK_BITS-1:0];
  assign lim_wide = {{TICK_BITS{1'b0}}, cfg.stale_limit_ms};
  assign lim_tk   = lim_wide[TICK_BITS-1:0];

  // Fresh classification and stepped update with hysteresis.
  always_comb begin
    if (h >= cfg.fast_threshold) begin
      spd_class = hwhc_pkg::SPD_FAST;
    end else if (h >= cfg.normal_threshold) begin
      spd_class = hwhc_pkg::SPD_NORMAL;
    end else if (h >= cfg.slow_threshold) begin
      spd_class = hwhc_pkg::SPD_SLOW;
    end else begin
      spd_class = hwhc_pkg::SPD_STOP;
    end

    if (h >= cfg.fast_threshold) begin
      spd_up = hwhc_pkg::SPD_FAST;
    end else if (h >= cfg.normal_threshold) begin
      spd_up = (auto_speed_r < hwhc_pkg::SPD_NORMAL) ? hwhc_pkg::SPD_NORMAL : auto_speed_r;
    end else if (h >= cfg.slow_threshold) begin
      spd_up = (auto_speed_r < hwhc_pkg::SPD_SLOW) ? hwhc_pkg::SPD_SLOW : auto_speed_r;
    end else begin
      spd_up = auto_speed_r;
    end

    spd_a = spd_up;
    if (spd_up == hwhc_pkg::SPD_FAST &&
        hwhc_pkg::below_margin(h, cfg.fast_threshold, cfg.wiper_hysteresis)) begin
      spd_a = hwhc_pkg::SPD_NORMAL;
    end
    spd_b = spd_a;
    if (spd_a == hwhc_pkg::SPD_NORMAL &&
        hwhc_pkg::below_margin(h, cfg.normal_threshold, cfg.wiper_hysteresis)) begin
      spd_b = hwhc_pkg::SPD_SLOW;
    end
    spd_c = spd_b;
    if (spd_b == hwhc_pkg::SPD_SLOW &&
        hwhc_pkg::below_margin(h, cfg.slow_threshold, cfg.wiper_hysteresis)) begin
      spd_c = hwhc_pkg::SPD_STOP;
    end
  end

  always_comb begin
    wiper_mode_nxt        = wiper_mode_r;
    heater_mode_nxt       = heater_mode_r;
    auto_speed_nxt        = auto_speed_r;
    auto_speed_valid_nxt  = auto_speed_valid_r;
    auto_heater_nxt       = auto_heater_r;
    auto_heater_valid_nxt = auto_heater_valid_r;
    sample_time_nxt       = sample_time_r;
    have_sample_nxt       = have_sample_r;

    case (item.operation)
      hwhc_pkg::OP_MODE: begin
        if (item.wiper_mode_req != hwhc_pkg::MODE_KEEP &&
            item.wiper_mode_req != wiper_mode_r) begin
          wiper_mode_nxt       = item.wiper_mode_req;
          auto_speed_valid_nxt = 1'b0;
        end
        if (item.heater_mode_req != hwhc_pkg::MODE_KEEP &&
            item.heater_mode_req != heater_mode_r) begin
          heater_mode_nxt       = item.heater_mode_req;
          auto_heater_valid_nxt = 1'b0;
        end
      end
      hwhc_pkg::OP_SAMPLE: begin
        sample_time_nxt = now_tk;
        have_sample_nxt = 1'b1;
        if (wiper_mode_r == hwhc_pkg::MODE_AUTO) begin
          auto_speed_nxt       = auto_speed_valid_r ? spd_c : spd_class;
          auto_speed_valid_nxt = 1'b1;
        end
        if (heater_mode_r == hwhc_pkg::MODE_AUTO) begin
          auto_heater_valid_nxt = 1'b1;
          if (!auto_heater_valid_r || !auto_heater_r) begin
            auto_heater_nxt = (h >= cfg.heater_threshold);
          end else begin
            auto_heater_nxt = !hwhc_pkg::below_margin(h, cfg.heater_threshold,
                                                      cfg.heater_hysteresis);
          end
        end
      end
      default: ;
    endcase
  end

  assign age   = now_tk - sample_time_nxt;
  assign stale = !have_sample_nxt || (age > lim_tk);

  always_comb begin
    case (wiper_mode_nxt)
      hwhc_pkg::MODE_OFF: speed = hwhc_pkg::SPD_STOP;
      hwhc_pkg::MODE_ON:  speed = hwhc_pkg::SPD_NORMAL;
      default:            speed = stale ? hwhc_pkg::SPD_STOP : auto_speed_nxt;
    endcase
    case (heater_mode_nxt)
      hwhc_pkg::MODE_OFF: heat = 1'b0;
      hwhc_pkg::MODE_ON:  heat = 1'b1;
      default:            heat = !stale && auto_heater_valid_nxt && auto_heater_nxt;
    endcase
  end

  assign sc      = !speed_sent_r || (speed != sent_speed_r);
  assign hc      = !heater_sent_r || (heat != sent_heater_r);
  assign emit    = sc || hc;
  assign advance = ctl.valid && (!emit || out_free);

  assign sent_speed_nxt  = sc ? speed : sent_speed_r;
  assign speed_sent_nxt  = speed_sent_r || sc;
  assign sent_heater_nxt = hc ? heat : sent_heater_r;
  assign heater_sent_nxt = heater_sent_r || hc;

  assign result.wiper_speed    = speed;
  assign result.heater_on      = heat;
  assign result.speed_changed  = sc;
  assign result.heater_changed = hc;
  assign result.stamp_ms       = item.now_ms;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wiper_mode_r        <= hwhc_pkg::MODE_AUTO;
      heater_mode_r       <= hwhc_pkg::MODE_AUTO;
      auto_speed_r        <= hwhc_pkg::SPD_STOP;
      auto_speed_valid_r  <= 1'b0;
      auto_heater_r       <= 1'b0;
      auto_heater_valid_r <= 1'b0;
      sample_time_r       <= '0;
      have_sample_r       <= 1'b0;
      sent_speed_r        <= hwhc_pkg::SPD_STOP;
      speed_sent_r        <= 1'b0;
      sent_heater_r       <= 1'b0;
      heater_sent_r       <= 1'b0;
    end else if (advance) begin
      wiper_mode_r        <= wiper_mode_nxt;
      heater_mode_r       <= heater_mode_nxt;
      auto_speed_r        <= auto_speed_nxt;
      auto_speed_valid_r  <= auto_speed_valid_nxt;
      auto_heater_r       <= auto_heater_nxt;
      auto_heater_valid_r <= auto_heater_valid_nxt;
      sample_time_r       <= sample_time_nxt;
      have_sample_r       <= have_sample_nxt;
      sent_speed_r        <= sent_speed_nxt;
      speed_sent_r        <= speed_sent_nxt;
      sent_heater_r       <= sent_heater_nxt;
      heater_sent_r       <= heater_sent_nxt;
    end
  end

endmodule

// ===== src/hwhc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwhc_out_stage
// Result register: hold a command until the sink takes the transfer.
// ----------------------------------------------------------------------------
module hwhc_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  hwhc_pkg::out_item_t item,
  output logic                free,
  hwhc_stream_if.source       out_if
);

  logic                valid_r;
  logic                valid_nxt;
  hwhc_pkg::out_item_t item_r;

  assign free      = !valid_r || out_if.ready;
  assign valid_nxt = load || (valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

  assign out_if.valid = valid_r;
  assign out_if.data  = item_r;

endmodule

// ===== src/humidity_wiper_heater_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_wiper_heater_controller
// Humidity-driven wiper speed and heater command with hysteresis.
// ----------------------------------------------------------------------------
// Takes one item per clock: a mode message, a humidity sample or a time tick.
// An item is registered on input, decided from that register against the
// mode, hysteresis and sample-age state, and a command goes to the result
// register for the first item after reset and otherwise only when the final
// speed or heater value changes. Throughput is one item per cycle; a command
// passes the input and result registers. The input stalls only when a
// command must be issued while the result register still holds one the sink
// has not taken. TICK_BITS sets the width of the tick arithmetic for sample age.
module humidity_wiper_heater_controller #(
  parameter int TICK_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hwhc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hwhc_pkg::CFG_DATA_W-1:0]   cfg_data,
  hwhc_stream_if.sink                       in_if,
  hwhc_stream_if.source                     out_if
);

  hwhc_pkg::cfg_regs_t  cfg;
  hwhc_pkg::stage_ctl_t ctl;
  hwhc_pkg::in_item_t   item;
  hwhc_pkg::out_item_t  result;
  logic                 advance;
  logic                 emit;
  logic                 out_free;

  hwhc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg)
  );

  hwhc_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .advance (advance),
    .ctl     (ctl),
    .item    (item)
  );

  hwhc_decide #(
    .TICK_BITS (TICK_BITS)
  ) u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .ctl      (ctl),
    .item     (item),
    .out_free (out_free),
    .advance  (advance),
    .emit     (emit),
    .result   (result)
  );

  hwhc_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance && emit),
    .item   (result),
    .free   (out_free),
    .out_if (out_if)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the humidity wiper and heater controller.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a valid/ready driver, and a monitor takes
// the commands on the result channel. Each accepted item runs through a
// local model of the modes, wiper and heater hysteresis, and sample age.
// Any command that model predicts is stored in order, and every command
// taken from the block is checked field by field against the oldest one.
// Directed items come first at reset settings. Random phases follow under
// several register settings, including both extremes and thresholds out of
// order. Both sides idle in random bursts, the sink once holds off long
// enough to back up the input, and the last phase runs without any idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD = 300;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [hwhc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hwhc_pkg::CFG_DATA_W-1:0] cfg_data;

  hwhc_stream_if #(.T(hwhc_pkg::in_item_t))  in_ch ();
  hwhc_stream_if #(.T(hwhc_pkg::out_item_t)) out_ch ();

  humidity_wiper_heater_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // Local copy of the register file.
  hwhc_pkg::cfg_regs_t cur_cfg = '{
    slow_threshold:    hwhc_pkg::RST_SLOW_THR,
    normal_threshold:  hwhc_pkg::RST_NORMAL_THR,
    fast_threshold:    hwhc_pkg::RST_FAST_THR,
    wiper_hysteresis:  hwhc_pkg::RST_WIPER_HYS,
    heater_threshold:  hwhc_pkg::RST_HEATER_THR,
    heater_hysteresis: hwhc_pkg::RST_HEATER_HYS,
    stale_limit_ms:    hwhc_pkg::RST_STALE_LIM
  };

  // Local copy of the controller state.
  logic [1:0]                   w_mode      = hwhc_pkg::MODE_AUTO;
  logic [1:0]                   h_mode      = hwhc_pkg::MODE_AUTO;
  logic [1:0]                   auto_lvl    = hwhc_pkg::SPD_STOP;
  logic                         lvl_ok      = 1'b0;
  logic                         auto_heat   = 1'b0;
  logic                         heat_ok     = 1'b0;
  logic [hwhc_pkg::STAMP_W-1:0] sample_ms   = '0;
  logic                         sample_seen = 1'b0;
  logic [7:0]                   sent_lvl    = 8'hFF;
  logic [7:0]                   sent_heat   = 8'hFF;

  hwhc_pkg::in_item_t  queued_items[$];
  hwhc_pkg::out_item_t cmd_fifo[$];

  int pushed_cnt   = 0;
  int accepted_cnt = 0;
  int err_cnt      = 0;
  int gap_left     = 0;
  int hold_left    = 0;
  bit src_idle     = 1'b1;
  bit snk_idle     = 1'b1;
  bit sink_pause_req = 1'b0;

  logic [hwhc_pkg::STAMP_W-1:0] clock_ms     = '0;
  logic [hwhc_pkg::STAMP_W-1:0] gen_sample_ms = '0;

  function automatic bit under_band(input int h, input int thr, input int hys);
    return h + hys < thr;
  endfunction

  task automatic absorb_item(input hwhc_pkg::in_item_t it);
    logic [1:0]                   nw;
    logic [1:0]                   nh;
    logic [1:0]                   lvl;
    logic                         heat;
    logic                         fresh;
    logic                         sc;
    logic                         hc;
    logic [hwhc_pkg::STAMP_W-1:0] age;
    int                           h;
    int                           whys;
    int                           hhys;
    hwhc_pkg::out_item_t          cmd;
    h    = int'(it.humidity_tenths);
    whys = int'(cur_cfg.wiper_hysteresis);
    hhys = int'(cur_cfg.heater_hysteresis);
    if (it.operation == hwhc_pkg::OP_MODE) begin
      nw = (it.wiper_mode_req == hwhc_pkg::MODE_KEEP) ? w_mode : it.wiper_mode_req;
      nh = (it.heater_mode_req == hwhc_pkg::MODE_KEEP) ? h_mode : it.heater_mode_req;
      if (nw != w_mode) begin
        w_mode = nw;
        lvl_ok = 1'b0;
      end
      if (nh != h_mode) begin
        h_mode  = nh;
        heat_ok = 1'b0;
      end
    end else if (it.operation == hwhc_pkg::OP_SAMPLE) begin
      sample_ms   = it.now_ms;
      sample_seen = 1'b1;
      if (w_mode == hwhc_pkg::MODE_AUTO) begin
        if (!lvl_ok) begin
          if (h >= cur_cfg.fast_threshold) auto_lvl = hwhc_pkg::SPD_FAST;
          else if (h >= cur_cfg.normal_threshold) auto_lvl = hwhc_pkg::SPD_NORMAL;
          else if (h >= cur_cfg.slow_threshold) auto_lvl = hwhc_pkg::SPD_SLOW;
          else auto_lvl = hwhc_pkg::SPD_STOP;
          lvl_ok = 1'b1;
        end else begin
          if (h >= cur_cfg.fast_threshold) begin
            auto_lvl = hwhc_pkg::SPD_FAST;
          end else if (h >= cur_cfg.normal_threshold) begin
            if (auto_lvl < hwhc_pkg::SPD_NORMAL) auto_lvl = hwhc_pkg::SPD_NORMAL;
          end else if (h >= cur_cfg.slow_threshold) begin
            if (auto_lvl < hwhc_pkg::SPD_SLOW) auto_lvl = hwhc_pkg::SPD_SLOW;
          end
          if (auto_lvl == hwhc_pkg::SPD_FAST &&
              under_band(h, int'(cur_cfg.fast_threshold), whys))
            auto_lvl = hwhc_pkg::SPD_NORMAL;
          if (auto_lvl == hwhc_pkg::SPD_NORMAL &&
              under_band(h, int'(cur_cfg.normal_threshold), whys))
            auto_lvl = hwhc_pkg::SPD_SLOW;
          if (auto_lvl == hwhc_pkg::SPD_SLOW &&
              under_band(h, int'(cur_cfg.slow_threshold), whys))
            auto_lvl = hwhc_pkg::SPD_STOP;
        end
      end
      if (h_mode == hwhc_pkg::MODE_AUTO) begin
        if (!heat_ok) begin
          auto_heat = (h >= cur_cfg.heater_threshold);
          heat_ok   = 1'b1;
        end else if (!auto_heat) begin
          if (h >= cur_cfg.heater_threshold) auto_heat = 1'b1;
        end else if (under_band(h, int'(cur_cfg.heater_threshold), hhys)) begin
          auto_heat = 1'b0;
        end
      end
    end

    age   = it.now_ms - sample_ms;
    fresh = sample_seen && (age <= cur_cfg.stale_limit_ms);

    case (w_mode)
      hwhc_pkg::MODE_OFF: lvl = hwhc_pkg::SPD_STOP;
      hwhc_pkg::MODE_ON:  lvl = hwhc_pkg::SPD_NORMAL;
      default:            lvl = fresh ? auto_lvl : hwhc_pkg::SPD_STOP;
    endcase
    case (h_mode)
      hwhc_pkg::MODE_OFF: heat = 1'b0;
      hwhc_pkg::MODE_ON:  heat = 1'b1;
      default:            heat = fresh && heat_ok && auto_heat;
    endcase

    sc = ({6'b0, lvl} != sent_lvl);
    hc = ({7'b0, heat} != sent_heat);
    if (sc || hc) begin
      if (sc) sent_lvl = {6'b0, lvl};
      if (hc) sent_heat = {7'b0, heat};
      cmd.wiper_speed    = lvl;
      cmd.heater_on      = heat;
      cmd.speed_changed  = sc;
      cmd.heater_changed = hc;
      cmd.stamp_ms       = it.now_ms;
      cmd_fifo.push_back(cmd);
    end
  endtask

  task automatic queue_fields(input logic [1:0] op, input logic [1:0] wreq,
                              input logic [1:0] hreq,
                              input logic [hwhc_pkg::HUM_W-1:0] hum,
                              input logic [hwhc_pkg::STAMP_W-1:0] now);
    hwhc_pkg::in_item_t it;
    it.operation       = op;
    it.wiper_mode_req  = wreq;
    it.heater_mode_req = hreq;
    it.humidity_tenths = hum;
    it.now_ms          = now;
    queued_items.push_back(it);
    pushed_cnt++;
  endtask

  task automatic write_reg(input logic [hwhc_pkg::CFG_IDX_W-1:0] idx, input int val);
    logic [hwhc_pkg::CFG_DATA_W-1:0] d;
    d = val[hwhc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      hwhc_pkg::CFG_SLOW_THR:   cur_cfg.slow_threshold    = d[hwhc_pkg::HUM_W-1:0];
      hwhc_pkg::CFG_NORMAL_THR: cur_cfg.normal_threshold  = d[hwhc_pkg::HUM_W-1:0];
      hwhc_pkg::CFG_FAST_THR:   cur_cfg.fast_threshold    = d[hwhc_pkg::HUM_W-1:0];
      hwhc_pkg::CFG_WIPER_HYS:  cur_cfg.wiper_hysteresis  = d[hwhc_pkg::HYS_W-1:0];
      hwhc_pkg::CFG_HEATER_THR: cur_cfg.heater_threshold  = d[hwhc_pkg::HUM_W-1:0];
      hwhc_pkg::CFG_HEATER_HYS: cur_cfg.heater_hysteresis = d[hwhc_pkg::HYS_W-1:0];
      hwhc_pkg::CFG_STALE_LIM:  cur_cfg.stale_limit_ms    = d[hwhc_pkg::LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input int slow, input int normal, input int fast,
                              input int whys, input int hthr, input int hhys,
                              input int stale);
    write_reg(hwhc_pkg::CFG_SLOW_THR, slow);
    write_reg(hwhc_pkg::CFG_NORMAL_THR, normal);
    write_reg(hwhc_pkg::CFG_FAST_THR, fast);
    write_reg(hwhc_pkg::CFG_WIPER_HYS, whys);
    write_reg(hwhc_pkg::CFG_HEATER_THR, hthr);
    write_reg(hwhc_pkg::CFG_HEATER_HYS, hhys);
    write_reg(hwhc_pkg::CFG_STALE_LIM, stale);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_setting();
    int s;
    int n;
    int f;
    if ($urandom_range(0, 3) != 0) begin
      s = $urandom_range(0, 600);
      n = s + $urandom_range(0, 200);
      f = n + $urandom_range(0, 200);
    end else begin
      s = $urandom_range(0, 1000);
      n = $urandom_range(0, 1000);
      f = $urandom_range(0, 1000);
    end
    load_setting(s, n, f, $urandom_range(0, 100), $urandom_range(0, 1000),
                 $urandom_range(0, 100),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 800));
  endtask

  // Wait for every item to be taken and every command to arrive, then let
  // the pipeline empty of items that produce no command.
  task automatic wait_settled();
    do @(negedge clk); while (accepted_cnt != pushed_cnt || cmd_fifo.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [1:0] lean_mode();
    int p;
    p = $urandom_range(0, 6);
    if (p < 3) return hwhc_pkg::MODE_AUTO;
    if (p == 3) return hwhc_pkg::MODE_ON;
    if (p == 4) return hwhc_pkg::MODE_OFF;
    return hwhc_pkg::MODE_KEEP;
  endfunction

  task automatic fill_random(input int n);
    logic [1:0]                 op;
    logic [1:0]                 wreq;
    logic [1:0]                 hreq;
    logic [hwhc_pkg::HUM_W-1:0] hum;
    logic [31:0]                r;
    int                         pick;
    int                         base;
    int                         span;
    int                         v;
    repeat (n) begin
      r    = $urandom_range(0, 3);
      wreq = r[1:0];
      r    = $urandom_range(0, 3);
      hreq = r[1:0];
      r    = $urandom_range(0, 1000);
      hum  = r[hwhc_pkg::HUM_W-1:0];
      pick = $urandom_range(0, 19);
      if (pick == 0) clock_ms = $urandom;
      else if (pick == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
      else if (pick < 4) clock_ms = gen_sample_ms + {16'b0, cur_cfg.stale_limit_ms} +
                                    $urandom_range(0, 2) - 32'd1;
      else if (pick < 6) clock_ms = clock_ms;
      else clock_ms = clock_ms + $urandom_range(1, 300);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        op   = hwhc_pkg::OP_MODE;
        wreq = lean_mode();
        hreq = lean_mode();
      end else if (pick < 60) begin
        op = hwhc_pkg::OP_SAMPLE;
        gen_sample_ms = clock_ms;
        pick = $urandom_range(0, 9);
        if (pick >= 2) begin
          case (pick % 4)
            0: base = int'(cur_cfg.slow_threshold);
            1: base = int'(cur_cfg.normal_threshold);
            2: base = int'(cur_cfg.fast_threshold);
            default: base = int'(cur_cfg.heater_threshold);
          endcase
          span = ((pick % 4) == 3) ? int'(cur_cfg.heater_hysteresis)
                                   : int'(cur_cfg.wiper_hysteresis);
          span = span + 4;
          v = base + $urandom_range(0, 2 * span) - span;
          if (v < 0) v = 0;
          if (v > 1000) v = 1000;
          hum = v[hwhc_pkg::HUM_W-1:0];
        end
      end else if (pick < 96) begin
        op = hwhc_pkg::OP_TICK;
      end else begin
        op = OP_SPARE;
      end
      queue_fields(op, wreq, hreq, hum, clock_ms);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : drive_items
    logic               nv;
    hwhc_pkg::in_item_t nd;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      nv = in_ch.valid;
      nd = in_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        absorb_item(in_ch.data);
        accepted_cnt++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_items.size() > 0) begin
          if (src_idle && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 19) - 1;
          end else begin
            nv = 1'b1;
            nd = queued_items.pop_front();
          end
        end
      end
      in_ch.valid <= nv;
      in_ch.data  <= nd;
    end
  end

  always @(posedge clk) begin : watch_cmds
    hwhc_pkg::out_item_t want;
    hwhc_pkg::out_item_t got;
    logic                nr;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (cmd_fifo.size() == 0) begin
          $error("transfer with no command pending, stamp_ms %0h", got.stamp_ms);
          err_cnt++;
        end else begin
          want = cmd_fifo.pop_front();
          if (got.wiper_speed !== want.wiper_speed) begin
            $error("wiper_speed expected %0d got %0d", want.wiper_speed, got.wiper_speed);
            err_cnt++;
          end
          if (got.heater_on !== want.heater_on) begin
            $error("heater_on expected %0d got %0d", want.heater_on, got.heater_on);
            err_cnt++;
          end
          if (got.speed_changed !== want.speed_changed) begin
            $error("speed_changed expected %0d got %0d", want.speed_changed,
                   got.speed_changed);
            err_cnt++;
          end
          if (got.heater_changed !== want.heater_changed) begin
            $error("heater_changed expected %0d got %0d", want.heater_changed,
                   got.heater_changed);
            err_cnt++;
          end
          if (got.stamp_ms !== want.stamp_ms) begin
            $error("stamp_ms expected %0h got %0h", want.stamp_ms, got.stamp_ms);
            err_cnt++;
          end
        end
      end
      if (sink_pause_req) begin
        sink_pause_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (snk_idle && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 19) - 1;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      out_ch.ready <= nr;
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = hwhc_pkg::CFG_SLOW_THR;
    cfg_data     = '0;
    rst_n        = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: first command, hysteresis steps, age edge, modes, wrap
    queue_fields(hwhc_pkg::OP_TICK,   hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd0,    32'd0);
    queue_fields(OP_SPARE,            hwhc_pkg::MODE_ON,   hwhc_pkg::MODE_ON,
                 10'd1000, 32'd5);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_OFF,  hwhc_pkg::MODE_OFF,
                 10'd0,    32'd1000);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_AUTO, hwhc_pkg::MODE_AUTO,
                 10'd1000, 32'd1010);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd398,  32'd1020);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd394,  32'd1030);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd346,  32'd1040);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd344,  32'd1050);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd296,  32'd1060);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd294,  32'd1070);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd400,  32'd1080);
    queue_fields(hwhc_pkg::OP_TICK,   hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd0,    32'd6080);
    queue_fields(hwhc_pkg::OP_TICK,   hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd0,    32'd6081);
    queue_fields(hwhc_pkg::OP_MODE,   hwhc_pkg::MODE_ON,   hwhc_pkg::MODE_KEEP,
                 10'd511,  32'd6082);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd500,  32'd6090);
    queue_fields(hwhc_pkg::OP_MODE,   hwhc_pkg::MODE_OFF,  hwhc_pkg::MODE_ON,
                 10'd0,    32'd6100);
    queue_fields(hwhc_pkg::OP_MODE,   hwhc_pkg::MODE_AUTO, hwhc_pkg::MODE_AUTO,
                 10'd0,    32'd6110);
    queue_fields(hwhc_pkg::OP_MODE,   hwhc_pkg::MODE_AUTO, hwhc_pkg::MODE_AUTO,
                 10'd1000, 32'd6115);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_ON,   hwhc_pkg::MODE_OFF,
                 10'd360,  32'd6120);
    queue_fields(hwhc_pkg::OP_MODE,   hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd1000, 32'd6130);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd700,  32'hFFFF_FFF0);
    queue_fields(hwhc_pkg::OP_TICK,   hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd0,    32'h0000_0100);
    queue_fields(hwhc_pkg::OP_TICK,   hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd0,    32'hFFFF_FFFF);
    queue_fields(hwhc_pkg::OP_SAMPLE, hwhc_pkg::MODE_KEEP, hwhc_pkg::MODE_KEEP,
                 10'd0,    32'h8000_0000);
    queue_fields(hwhc_pkg::OP_MODE,   hwhc_pkg::MODE_OFF,  hwhc_pkg::MODE_OFF,
                 10'd0,    32'h8000_0001);
    clock_ms      = 32'h8000_0001;
    gen_sample_ms = 32'h8000_0000;
    wait_settled();

    // hold the sink off long enough to back up the input
    load_setting(int'(hwhc_pkg::RST_SLOW_THR), int'(hwhc_pkg::RST_NORMAL_THR),
                 int'(hwhc_pkg::RST_FAST_THR), int'(hwhc_pkg::RST_WIPER_HYS),
                 int'(hwhc_pkg::RST_HEATER_THR), int'(hwhc_pkg::RST_HEATER_HYS),
                 int'(hwhc_pkg::RST_STALE_LIM));
    sink_pause_req = 1'b1;
    fill_random(250);
    wait_settled();

    load_setting(0, 0, 0, 100, 0, 100, 0);
    fill_random(200);
    wait_settled();

    src_idle = 1'b0;
    load_setting(1000, 1000, 1000, 0, 1000, 0, 65535);
    fill_random(200);
    wait_settled();

    src_idle = 1'b1;
    load_setting(700, 400, 200, 50, 600, 20, 1000);
    fill_random(200);
    wait_settled();

    // pause the source mid-phase until every command has arrived
    repeat (4) begin
      random_setting();
      fill_random(100);
      wait_settled();
      fill_random(100);
      wait_settled();
    end

    src_idle = 1'b0;
    snk_idle = 1'b0;
    random_setting();
    fill_random(275);
    wait_settled();

    if (err_cnt == 0 && cmd_fifo.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
